FILE: rtl/core/pomsm_pkg.sv
// Package for the open-mode serial register-bus master.
// Holds the field widths, reset constants and the result record.
// No dependencies.
package pomsm_pkg;

  localparam int DEF_ADDR_BITS  = 6;
  localparam int DEF_DATA_BITS  = 24;
  localparam int FIELD_BITS     = 24;   // write_data and read_data port width
  localparam int HP_BITS        = 8;
  localparam logic [HP_BITS-1:0] HALF_PERIOD_RESET = 8'd2;

  typedef struct packed {
    logic                  csn;
    logic                  sck;
    logic                  mosi;
    logic                  busy_res;
    logic                  done_res;
    logic [FIELD_BITS-1:0] read_data;
  } pomsm_result_t;

endpackage

FILE: rtl/core/pll_open_mode_spi_master_unit.sv
// Open-mode serial register-bus master: one input transaction per clock tick
// of the serial engine, one result transaction per input transaction.
// Input accept to result valid: input queue register, then the engine step
// into the result queue register. Throughput: 1 transaction per cycle unless
// stalled, set by the single-step frame engine between two 2-entry queues.
// Reset (rst, synchronous): queues empty, frame idle, half_period = 2.
module pll_open_mode_spi_master_unit
  import pomsm_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [HP_BITS-1:0]    cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  start_req,
  input  logic                  op,
  input  logic [ADDR_BITS-1:0]  address,
  input  logic [FIELD_BITS-1:0] write_data,
  input  logic                  miso,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  csn,
  output logic                  sck,
  output logic                  mosi,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [FIELD_BITS-1:0] read_data
);

  localparam int FRAME_BITS = 1 + ADDR_BITS + DATA_BITS;
  localparam int RES_W      = $bits(pomsm_result_t);

  logic                  item_valid;
  logic                  item_ready;
  logic                  item_start;
  logic [FRAME_BITS-1:0] item_word;
  logic                  item_miso;
  logic                  res_valid;
  logic                  res_ready;
  pomsm_result_t         res;
  pomsm_result_t         res_q;
  logic [RES_W-1:0]      res_q_bits;

  pomsm_front #(
    .ADDR_BITS(ADDR_BITS),
    .DATA_BITS(DATA_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .start_req  (start_req),
    .op         (op),
    .address    (address),
    .write_data (write_data),
    .miso       (miso),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_start (item_start),
    .item_word  (item_word),
    .item_miso  (item_miso)
  );

  pomsm_engine #(
    .ADDR_BITS(ADDR_BITS),
    .DATA_BITS(DATA_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item_start  (item_start),
    .item_word   (item_word),
    .item_miso   (item_miso),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  pomsm_fifo #(
    .WIDTH(RES_W)
  ) u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_ready (res_ready),
    .wr_data  (res),
    .rd_valid (out_valid),
    .rd_ready (~out_stall),
    .rd_data  (res_q_bits)
  );

  assign res_q     = pomsm_result_t'(res_q_bits);
  assign csn       = res_q.csn;
  assign sck       = res_q.sck;
  assign mosi      = res_q.mosi;
  assign busy_res  = res_q.busy_res;
  assign done_res  = res_q.done_res;
  assign read_data = res_q.read_data;

endmodule

FILE: rtl/core/pomsm_fifo.sv
// Two-entry queue with valid/ready on both sides.
// Used between front and engine and on the result side. Uses no package items.
module pomsm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/pomsm_front.sv
// Front end: takes input transactions, builds the frame word for each one and
// queues it for the engine. Depends on pomsm_pkg, pomsm_fifo.
module pomsm_front
  import pomsm_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          start_req,
  input  logic                          op,
  input  logic [ADDR_BITS-1:0]          address,
  input  logic [FIELD_BITS-1:0]         write_data,
  input  logic                          miso,
  output logic                          item_valid,
  input  logic                          item_ready,
  output logic                          item_start,
  output logic [ADDR_BITS+DATA_BITS:0]  item_word,
  output logic                          item_miso
);

  localparam int FRAME_BITS = 1 + ADDR_BITS + DATA_BITS;
  localparam int EXT_W      = (DATA_BITS > FIELD_BITS) ? DATA_BITS : FIELD_BITS;
  localparam int Q_W        = FRAME_BITS + 2;

  logic                  in_ready;
  logic [EXT_W-1:0]      data_ext;
  logic [DATA_BITS-1:0]  data_field;
  logic [FRAME_BITS-1:0] word;
  logic [Q_W-1:0]        q_in;
  logic [Q_W-1:0]        q_out;

  always_comb begin
    data_ext   = EXT_W'(write_data);
    data_field = op ? '0 : data_ext[DATA_BITS-1:0];
    word       = {op, address, data_field};
    q_in       = {start_req, word, miso};
  end

  assign in_stall = ~in_ready;

  pomsm_fifo #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (q_in),
    .rd_valid (item_valid),
    .rd_ready (item_ready),
    .rd_data  (q_out)
  );

  assign item_start = q_out[Q_W-1];
  assign item_word  = q_out[Q_W-2:1];
  assign item_miso  = q_out[0];

endmodule

FILE: rtl/core/pomsm_engine.sv
// Back end: the serial frame engine, one tick per queued transaction.
// Holds half_period and all frame state. Depends on pomsm_pkg.
module pomsm_engine
  import pomsm_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [HP_BITS-1:0]            cfg_wr_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          item_start,
  input  logic [ADDR_BITS+DATA_BITS:0]  item_word,
  input  logic                          item_miso,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pomsm_result_t                 res
);

  localparam int FRAME_BITS = 1 + ADDR_BITS + DATA_BITS;
  localparam int DATA_START = 1 + ADDR_BITS;
  localparam int BP_W       = $clog2(FRAME_BITS + 1);
  localparam int EXT_W      = (DATA_BITS > FIELD_BITS) ? DATA_BITS : FIELD_BITS;

  logic [HP_BITS-1:0]    half_period;
  logic                  frame_active, frame_active_next;
  logic                  is_read, is_read_next;
  logic [BP_W-1:0]       bit_position, bit_position_next;
  logic                  clock_high_phase, clock_high_phase_next;
  logic [HP_BITS-1:0]    tick_count, tick_count_next;
  logic [FRAME_BITS-1:0] out_shift, out_shift_next;
  logic [DATA_BITS-1:0]  in_shift, in_shift_next;
  logic [FIELD_BITS-1:0] read_hold, read_hold_next;
  logic [HP_BITS-1:0]    hp;
  logic [HP_BITS-1:0]    tick_inc;
  logic [EXT_W-1:0]      in_ext;
  logic                  done;
  logic                  fire;

  assign item_ready = res_ready;
  assign res_valid  = item_valid;
  assign fire       = item_valid && res_ready;

  always_comb begin
    hp                    = (half_period == '0) ? HP_BITS'(1) : half_period;
    tick_inc              = tick_count + HP_BITS'(1);
    in_ext                = EXT_W'(in_shift);
    frame_active_next     = frame_active;
    is_read_next          = is_read;
    bit_position_next     = bit_position;
    clock_high_phase_next = clock_high_phase;
    tick_count_next       = tick_count;
    out_shift_next        = out_shift;
    in_shift_next         = in_shift;
    read_hold_next        = read_hold;
    done                  = 1'b0;
    if (!frame_active) begin
      if (item_start) begin
        out_shift_next        = item_word;
        is_read_next          = item_word[FRAME_BITS-1];
        frame_active_next     = 1'b1;
        bit_position_next     = '0;
        clock_high_phase_next = 1'b0;
        tick_count_next       = '0;
        in_shift_next         = '0;
      end
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= hp) begin
        tick_count_next = '0;
        if (!clock_high_phase) begin
          clock_high_phase_next = 1'b1;
          if (is_read && bit_position >= BP_W'(DATA_START) &&
              bit_position < BP_W'(FRAME_BITS)) begin
            in_shift_next = {in_shift[DATA_BITS-2:0], item_miso};
          end
        end else begin
          clock_high_phase_next = 1'b0;
          bit_position_next     = bit_position + BP_W'(1);
          // the next bit moves up to the MSB, which drives mosi
          out_shift_next        = out_shift << 1;
          if (bit_position == BP_W'(FRAME_BITS)) begin
            frame_active_next = 1'b0;
            bit_position_next = '0;
            done              = 1'b1;
            if (is_read) begin
              read_hold_next = in_ext[FIELD_BITS-1:0];
            end
          end
        end
      end
    end
  end

  always_comb begin
    res.csn       = frame_active_next;
    res.sck       = frame_active_next && clock_high_phase_next;
    res.mosi      = frame_active_next && (bit_position_next < BP_W'(FRAME_BITS)) &&
                    out_shift_next[FRAME_BITS-1];
    res.busy_res  = frame_active_next;
    res.done_res  = done;
    res.read_data = read_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      half_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active     <= 1'b0;
      is_read          <= 1'b0;
      bit_position     <= '0;
      clock_high_phase <= 1'b0;
      tick_count       <= '0;
      read_hold        <= '0;
    end else if (fire) begin
      frame_active     <= frame_active_next;
      is_read          <= is_read_next;
      bit_position     <= bit_position_next;
      clock_high_phase <= clock_high_phase_next;
      tick_count       <= tick_count_next;
      read_hold        <= read_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_shift <= out_shift_next;
      in_shift  <= in_shift_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !frame_active |-> (bit_position == '0 && !clock_high_phase))
    else $error("idle engine holds a stale bit position or clock phase");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (bit_position <= BP_W'(FRAME_BITS)))
    else $error("bit position ran past the final clock pulse");

  a_start_load: assert property (@(posedge clk) disable iff (rst)
    (fire && !frame_active && item_start) |=> (frame_active && tick_count == '0))
    else $error("start request did not open a frame");

  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    (fire && !done) |=> $stable(read_hold))
    else $error("read word changed outside the end of a frame");
`endif

endmodule
